[hw/rtl/adz_pkg.sv]
// Shared constants and types for the analog axis dead-zone unit.
`default_nettype none
package adz_pkg;

    // Result widths
    localparam int OUT_W    = 16;
    localparam int FRAC_W   = 15;

    // Iterations of the root and divider pipelines (one result bit per stage)
    localparam int STEPS    = 16;

    localparam logic [OUT_W-1:0]  OUT_ONE  = 16'h8000;
    localparam logic [FRAC_W-1:0] OUT_MAXV = 15'h7fff;

    // Configuration register indexes
    localparam logic [1:0] CFG_DZ_ONE = 2'd0;
    localparam logic [1:0] CFG_DZ_TWO = 2'd1;
    localparam logic [1:0] CFG_FULL   = 2'd2;

    // Modes
    localparam logic FUNC_TRIGGER = 1'b0;
    localparam logic FUNC_STICK   = 1'b1;

    // Per-request side information that travels alongside the arithmetic
    typedef struct packed {
        logic        vld;
        logic        func;
        logic        neg_x;
        logic        neg_y;
        logic [15:0] ax;
        logic [15:0] ay;
        logic        zero;
        logic        sat;
        logic [15:0] len;
        logic [15:0] f;
    } t_side;

endpackage
`default_nettype wire

[hw/rtl/adz_delay.sv]
// Delay line that carries request side information past a pipelined unit.
`default_nettype none
module adz_delay (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  adz_pkg::t_side   i_side,
    output adz_pkg::t_side   o_side
);

    adz_pkg::t_side r_pipe [0:adz_pkg::STEPS-1];
    adz_pkg::t_side n_pipe [0:adz_pkg::STEPS-1];

    // Shift one place per cycle; clear only the valid bits on reset
    always_comb begin
        n_pipe[0]     = i_side;
        n_pipe[0].vld = i_side.vld & i_rst_n;
        for (int k = 1; k < adz_pkg::STEPS; k++) begin
            n_pipe[k]     = r_pipe[k-1];
            n_pipe[k].vld = r_pipe[k-1].vld & i_rst_n;
        end
    end

    // Advance every cycle
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < adz_pkg::STEPS; k++) begin
            r_pipe[k] <= n_pipe[k];
        end
    end

    assign o_side = r_pipe[adz_pkg::STEPS-1];

endmodule
`default_nettype wire

[hw/rtl/adz_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`default_nettype none
module adz_sqrt (
    input  wire         i_clk,
    input  wire  [31:0] i_rad,
    output logic [15:0] o_root
);

    localparam int N = adz_pkg::STEPS;

    logic [17:0] r_rem  [0:N-2];
    logic [31:0] r_rad  [0:N-2];
    logic [15:0] r_root [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [17:0] rem_in;
        logic [31:0] rad_in;
        logic [15:0] root_in;
        logic [19:0] trial_rem;
        logic [17:0] trial;
        logic        ge;
        logic [15:0] n_root;

        if (k == 0) begin : g_first
            assign rem_in  = 18'd0;
            assign rad_in  = i_rad;
            assign root_in = 16'd0;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign rad_in  = r_rad[k-1];
            assign root_in = r_root[k-1];
        end

        // Bring down two radicand bits and try the next root bit
        assign trial_rem = {rem_in, rad_in[31:30]};
        assign trial     = {root_in, 2'b01};
        assign ge        = trial_rem >= {2'b00, trial};
        assign n_root    = {root_in[14:0], ge};

        always_ff @(posedge i_clk) begin
            r_root[k] <= n_root;
        end

        if (k < N - 1) begin : g_carry
            logic [19:0] diff;
            logic [17:0] n_rem;
            assign diff  = trial_rem - {2'b00, trial};
            assign n_rem = ge ? diff[17:0] : trial_rem[17:0];
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_rad[k] <= {rad_in[29:0], 2'b00};
            end
        end
    end

    assign o_root = r_root[N-1];

endmodule
`default_nettype wire

[hw/rtl/adz_div.sv]
// Pipelined restoring divider: 32-bit dividend over 16-bit divisor, 16-bit quotient.
`default_nettype none
module adz_div (
    input  wire         i_clk,
    input  wire  [31:0] i_dividend,
    input  wire  [15:0] i_divisor,
    output logic [15:0] o_quot
);

    // The dividend's upper half must be below the divisor
    localparam int N = adz_pkg::STEPS;

    logic [15:0] r_rem [0:N-2];
    logic [15:0] r_low [0:N-2];
    logic [15:0] r_dvs [0:N-2];
    logic [15:0] r_q   [0:N-1];

    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [15:0] rem_in;
        logic [15:0] low_in;
        logic [15:0] dvs_in;
        logic [15:0] q_in;
        logic [16:0] t;
        logic        ge;

        if (k == 0) begin : g_first
            assign rem_in = i_dividend[31:16];
            assign low_in = i_dividend[15:0];
            assign dvs_in = i_divisor;
            assign q_in   = 16'd0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign low_in = r_low[k-1];
            assign dvs_in = r_dvs[k-1];
            assign q_in   = r_q[k-1];
        end

        // Shift in one dividend bit and subtract where it fits
        assign t    = {rem_in, low_in[15]};
        assign ge   = t >= {1'b0, dvs_in};

        always_ff @(posedge i_clk) begin
            r_q[k] <= {q_in[14:0], ge};
        end

        if (k < N - 1) begin : g_carry
            logic [16:0] diff;
            logic [15:0] n_rem;
            assign diff  = t - {1'b0, dvs_in};
            assign n_rem = ge ? diff[15:0] : t[15:0];
            always_ff @(posedge i_clk) begin
                r_rem[k] <= n_rem;
                r_low[k] <= {low_in[14:0], 1'b0};
                r_dvs[k] <= dvs_in;
            end
        end
    end

    assign o_quot = r_q[N-1];

endmodule
`default_nettype wire

[hw/rtl/analog_axis_dead_zone_unit.sv]
// Top level of the analog axis dead-zone unit: config registers and main pipeline.
//
// Use: raise i_start with i_func, i_x_sample and i_y_sample; the request is
// taken at any rising edge where i_start is high and o_busy is low. o_busy is
// never raised, so one request can enter in every cycle.
// func 0 (trigger) scales |x| past the one-axis dead zone; func 1 (stick)
// rescales the vector (x,y) by its length past the two-axis dead zone.
// Each result shows on o_out_x / o_out_y for one cycle with o_out_valid high,
// after it has passed three front stages (magnitudes, squares, sum), a 16-stage
// root, one fraction stage, a 16-stage fraction divider, one multiply stage, a
// 16-stage output divider and the output register.
// Throughput is one request per cycle; results leave in request order.
// The receiver cannot stall; results are not held.
// Configuration: write i_cfg_index / i_cfg_data with i_cfg_valid; o_cfg_ready
// is always high. Index 0 one-axis dead zone, 1 two-axis dead zone, 2 full
// scale; other indexes are dropped. Write only with no requests in flight.
// Reset (synchronous, i_rst_n low) restores 250 / 8000 / 30000 and empties
// the pipeline.
`default_nettype none
module analog_axis_dead_zone_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_start,
    output logic        o_busy,
    input  wire         i_func,
    input  wire  [15:0] i_x_sample,
    input  wire  [15:0] i_y_sample,
    output logic        o_out_valid,
    output logic [15:0] o_out_x,
    output logic [15:0] o_out_y,
    input  wire         i_cfg_valid,
    output logic        o_cfg_ready,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [14:0] i_cfg_data
);

    logic [14:0] r_dz1;
    logic [14:0] r_dz2;
    logic [14:0] r_full;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dz1  <= 15'd250;
            r_dz2  <= 15'd8000;
            r_full <= 15'd30000;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                adz_pkg::CFG_DZ_ONE: r_dz1  <= i_cfg_data;
                adz_pkg::CFG_DZ_TWO: r_dz2  <= i_cfg_data;
                adz_pkg::CFG_FULL:   r_full <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Stage 1: magnitudes and signs
    adz_pkg::t_side r_s1;
    logic [15:0] n_ax;
    logic [15:0] n_ay;

    assign n_ax = i_x_sample[15] ? 16'(-i_x_sample) : i_x_sample;
    assign n_ay = i_y_sample[15] ? 16'(-i_y_sample) : i_y_sample;

    always_ff @(posedge i_clk) begin
        r_s1.vld   <= i_start & i_rst_n;
        r_s1.func  <= i_func;
        r_s1.neg_x <= i_x_sample[15];
        r_s1.neg_y <= i_y_sample[15];
        r_s1.ax    <= n_ax;
        r_s1.ay    <= n_ay;
        r_s1.zero  <= 1'b0;
        r_s1.sat   <= 1'b0;
        r_s1.len   <= 16'd0;
        r_s1.f     <= 16'd0;
    end

    // Stage 2: squares
    adz_pkg::t_side r_s2;
    adz_pkg::t_side n_s2;
    logic [31:0] r_xx;
    logic [31:0] r_yy;
    logic [29:0] r_dzsq;

    always_comb begin
        n_s2     = r_s1;
        n_s2.vld = r_s1.vld & i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_s2   <= n_s2;
        r_xx   <= 32'(r_s1.ax * r_s1.ax);
        r_yy   <= 32'(r_s1.ay * r_s1.ay);
        r_dzsq <= 30'(r_dz2 * r_dz2);
    end

    // Stage 3: squared length and dead-zone tests
    adz_pkg::t_side r_s3;
    adz_pkg::t_side n_s3;
    logic [31:0] r_rad;
    logic [31:0] n_sum;
    logic        n_zero;

    assign n_sum  = r_xx + r_yy;
    assign n_zero = (r_s2.func == adz_pkg::FUNC_STICK)
                  ? ((n_sum == 32'd0) || (n_sum < {2'b00, r_dzsq}))
                  : (r_s2.ax <= {1'b0, r_dz1});

    always_comb begin
        n_s3      = r_s2;
        n_s3.zero = n_zero;
        n_s3.vld  = r_s2.vld & i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_s3  <= n_s3;
        r_rad <= n_sum;
    end

    // Root of the squared length
    adz_pkg::t_side s_sq;
    logic [15:0] s_root;

    adz_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_rad  (r_rad),
        .o_root (s_root)
    );

    adz_delay u_dly_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_s3),
        .o_side  (s_sq)
    );

    // Fraction numerator, denominator and saturation per mode
    adz_pkg::t_side r_sf;
    adz_pkg::t_side n_sf;
    logic [31:0] r_fdvd;
    logic [15:0] r_fdvs;
    logic [15:0] n_num;
    logic [15:0] n_den;
    logic        n_sat;

    always_comb begin
        if (s_sq.func == adz_pkg::FUNC_STICK) begin
            n_num = s_root - {1'b0, r_dz2};
            n_den = {1'b0, r_full} - {1'b0, r_dz2};
            n_sat = (r_full <= r_dz2) || (s_root >= {1'b0, r_full});
        end else begin
            n_num = s_sq.ax - {1'b0, r_dz1};
            n_den = {1'b0, r_full} - {1'b0, r_dz1};
            n_sat = (r_full <= r_dz1) || (n_num >= n_den);
        end
    end

    always_comb begin
        n_sf     = s_sq;
        n_sf.len = s_root;
        n_sf.sat = n_sat;
        n_sf.vld = s_sq.vld & i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_sf   <= n_sf;
        r_fdvd <= {1'b0, n_num, 15'd0};
        r_fdvs <= n_den;
    end

    // Fraction divider
    adz_pkg::t_side s_fd;
    logic [15:0] s_fq;

    adz_div u_div_frac (
        .i_clk      (i_clk),
        .i_dividend (r_fdvd),
        .i_divisor  (r_fdvs),
        .o_quot     (s_fq)
    );

    adz_delay u_dly_frac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_sf),
        .o_side  (s_fd)
    );

    // Scale magnitudes by the fraction
    adz_pkg::t_side r_sm;
    adz_pkg::t_side n_sm;
    logic [31:0] r_px;
    logic [31:0] r_py;
    logic [15:0] n_f;

    assign n_f = s_fd.sat ? adz_pkg::OUT_ONE : s_fq;

    always_comb begin
        n_sm     = s_fd;
        n_sm.f   = n_f;
        n_sm.vld = s_fd.vld & i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        r_sm <= n_sm;
        r_px <= 32'(s_fd.ax * n_f);
        r_py <= 32'(s_fd.ay * n_f);
    end

    // Divide the scaled magnitudes by the length
    adz_pkg::t_side s_od;
    logic [15:0] s_qx;
    logic [15:0] s_qy;

    adz_div u_div_x (
        .i_clk      (i_clk),
        .i_dividend (r_px),
        .i_divisor  (r_sm.len),
        .o_quot     (s_qx)
    );

    adz_div u_div_y (
        .i_clk      (i_clk),
        .i_dividend (r_py),
        .i_divisor  (r_sm.len),
        .o_quot     (s_qy)
    );

    adz_delay u_dly_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_side  (r_sm),
        .o_side  (s_od)
    );

    // Saturate, restore signs and register the result
    logic [15:0] n_mx;
    logic [15:0] n_my;
    logic [14:0] n_cx;
    logic [14:0] n_cy;
    logic [15:0] n_out_x;
    logic [15:0] n_out_y;
    logic        r_out_valid;
    logic [15:0] r_out_x;
    logic [15:0] r_out_y;

    always_comb begin
        if (s_od.func == adz_pkg::FUNC_STICK) begin
            n_mx = s_qx;
            n_my = s_qy;
        end else begin
            n_mx = s_od.f;
            n_my = 16'd0;
        end
        n_cx = n_mx[15] ? adz_pkg::OUT_MAXV : n_mx[14:0];
        n_cy = n_my[15] ? adz_pkg::OUT_MAXV : n_my[14:0];
        n_out_x = s_od.neg_x ? 16'(-{1'b0, n_cx}) : {1'b0, n_cx};
        n_out_y = (s_od.neg_y && s_od.func == adz_pkg::FUNC_STICK)
                ? 16'(-{1'b0, n_cy}) : {1'b0, n_cy};
        if (s_od.zero) begin
            n_out_x = 16'd0;
            n_out_y = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= s_od.vld;
        end
        r_out_x <= n_out_x;
        r_out_y <= n_out_y;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;

endmodule
`default_nettype wire
